[rtl/fifo_queue_with_search_purge_macros.svh]
// ----------------------------------------------------------------------------
// fifo_queue_with_search_purge_macros
// Assertion macros for the queue RTL; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_PURGE_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_PURGE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define FQSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed");

// Next-cycle implication, checked outside reset.
`define FQSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed");

`else

`define FQSP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FQSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/fqsp_pkg.sv]
// ----------------------------------------------------------------------------
// fqsp_pkg
// Types, sizes and helpers for the searchable queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqsp_pkg;

   localparam int DEPTH  = 16;
   localparam int ELEM_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int CMD_W  = 2;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ   = 2'd0,
      CMD_DEQ   = 2'd1,
      CMD_FIND  = 2'd2,
      CMD_PURGE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_DEQ,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              en;
      logic [PTR_W-1:0]  addr;
      logic [ELEM_W-1:0] data;
   } mem_wr_type;

   // Physical slot of a logical offset from the head, wrapping at DEPTH.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                input logic [PTR_W-1:0] offset);
      logic [PTR_W:0] sum;
      sum = {1'b0, head} + {1'b0, offset};
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/fqsp_req_if.sv]
// ----------------------------------------------------------------------------
// fqsp_req_if
// Command channel: valid/ready handshake carrying a command and its operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fqsp_req_if
   import fqsp_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [VAL_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

[rtl/fqsp_rsp_if.sv]
// ----------------------------------------------------------------------------
// fqsp_rsp_if
// Result channel: valid/ready handshake carrying status, data and occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fqsp_rsp_if
   import fqsp_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [DATA_W-1:0] data;
   logic              found;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output status, output data, output found,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input data, input found,
                   input occupancy, output ready);
endinterface

`default_nettype wire

[rtl/fifo_queue_with_search_purge.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search_purge
// First-in first-out queue whose entries can also be searched for a key or
// purged of every entry equal to a key, keeping the order of the rest.
// ----------------------------------------------------------------------------
// After acceptance each command passes S_START, then S_RESP; a dequeue from
// a non-empty queue passes S_DEQ between them, and a search or purge of a
// non-empty queue passes S_SCAN, one entry per cycle through the single
// storage read port and one shared comparator. One item is in work at a
// time; the next is accepted the cycle after S_RESP registers the result,
// which it does once the output is free. Synchronous reset empties the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_queue_with_search_purge_macros.svh"

module fifo_queue_with_search_purge
   import fqsp_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   fqsp_req_if.sink   req_chan,
   fqsp_rsp_if.source rsp_chan
);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ELEM_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   status_type        status_ff, status_in;
   logic [ELEM_W-1:0] data_ff, data_in;
   logic              found_ff, found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   mem_wr_type        mem_wr;
   logic [PTR_W-1:0]  rd_addr;
   logic [ELEM_W-1:0] rd_data;
   logic              hit;
   logic [CNT_W-1:0]  idx_next;
   logic [CNT_W-1:0]  kept_next;

   fqsp_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The one comparator, shared by search and purge.
   assign hit       = (rd_data == key_ff);
   assign idx_next  = CNT_W'(idx_ff) + CNT_W'(1);
   assign kept_next = kept_ff + CNT_W'((cmd_ff == CMD_PURGE) && !hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      kept_ff       <= kept_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_wr.en     = 1'b0;
      mem_wr.addr   = slot_of(head_ff, kept_ff[PTR_W-1:0]);
      mem_wr.data   = rd_data;
      rd_addr       = head_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in    = cmd_type'(req_chan.cmd);
               key_in    = req_chan.value[ELEM_W-1:0];
               status_in = ST_DONE;
               data_in   = '0;
               found_in  = 1'b0;
               state_in  = S_START;
            end
         end

         S_START: begin
            case (cmd_ff)
               CMD_ENQ: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = slot_of(head_ff, count_ff[PTR_W-1:0]);
                     mem_wr.data = key_ff;
                     count_in    = count_ff + CNT_W'(1);
                  end
                  state_in = S_RESP;
               end
               CMD_DEQ: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_DEQ;
                  end
               end
               default: begin
                  // Search and purge walk the entries from the head.
                  idx_in  = '0;
                  kept_in = '0;
                  if (count_ff == '0) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            endcase
         end

         S_DEQ: begin
            data_in  = rd_data;
            head_in  = slot_of(head_ff, PTR_W'(1));
            count_in = count_ff - CNT_W'(1);
            state_in = S_RESP;
         end

         S_SCAN: begin
            if ((cmd_ff == CMD_FIND) && hit) begin
               found_in = 1'b1;
            end
            // Kept entries are packed down towards the head; the write slot
            // never reaches the slot read next.
            if ((cmd_ff == CMD_PURGE) && !hit) begin
               mem_wr.en = 1'b1;
            end
            kept_in = kept_next;
            if (idx_next == count_ff) begin
               if (cmd_ff == CMD_PURGE) begin
                  count_in = kept_next;
               end
               state_in = S_RESP;
            end else begin
               rd_addr = slot_of(head_ff, idx_next[PTR_W-1:0]);
               idx_in  = idx_next[PTR_W-1:0];
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = DATA_W'(data_ff);
               rsp_found_in  = found_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.data      = rsp_data_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

   `FQSP_ASSERT_IMPLY(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `FQSP_ASSERT_NEXT(a_accept_starts, clock, reset, req_chan.valid && req_chan.ready, state_ff == S_START)
   `FQSP_ASSERT_NEXT(a_deq_decrements, clock, reset, state_ff == S_DEQ, count_ff == $past(count_ff) - CNT_W'(1))
   `FQSP_ASSERT_NEXT(a_purge_never_grows, clock, reset, state_ff == S_SCAN, count_ff <= $past(count_ff))
   `FQSP_ASSERT_NEXT(a_resp_loads, clock, reset, state_ff == S_RESP && (!rsp_valid_ff || rsp_chan.ready), rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire

[rtl/fqsp_store.sv]
// ----------------------------------------------------------------------------
// fqsp_store
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqsp_store
   import fqsp_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_wr_type        wr,
   input  wire logic [PTR_W-1:0]  rd_addr,
   output logic      [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[tb/sv/fifo_queue_with_search_purge_tb.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search_purge_tb
// Self-checking bench for the searchable queue. A short table of commands
// covers the empty and full cases, the extreme values, search and purge.
// Several hundred random commands follow, keyed mostly from a small pool so
// that searches and purges hit. Each result is checked against a typed-in
// reply or a shadow copy of the queue, and both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_queue_with_search_purge_tb
   import fqsp_pkg::*;
;

   localparam int RANDOM_ITEMS = 625;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] data;
      logic              found;
      logic [OCC_W-1:0]  occupancy;
   } queue_reply_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [VAL_W-1:0]  value;
      logic [7:0]        reps;
      logic              typed;
      queue_reply_type   reply;
   } command_row_type;

   logic clock;
   logic reset;

   fqsp_req_if req_chan ();
   fqsp_rsp_if rsp_chan ();

   fifo_queue_with_search_purge u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the queue contents.
   logic [ELEM_W-1:0] shadow_slots [DEPTH];
   int unsigned       shadow_head;
   int unsigned       shadow_held;

   queue_reply_type replies_due [$];

   int unsigned mismatches;
   int unsigned results_taken;
   int unsigned commands_sent;
   int unsigned cmd_seen [4];
   int unsigned full_rejects;
   int unsigned empty_dequeues;
   int unsigned search_hits;
   int unsigned entries_purged;
   bit          send_quiet;
   bit          take_quiet;

   logic [VAL_W-1:0] key_pool [8];
   command_row_type  directed_rows [14];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Works out the result of one command and updates the shadow queue.
   function automatic queue_reply_type apply_queue_command(input cmd_type cmd,
                                                           input logic [VAL_W-1:0] value);
      queue_reply_type   r;
      logic [ELEM_W-1:0] key;
      logic [ELEM_W-1:0] e;
      int unsigned       kept;
      r = '{ST_DONE, '0, 1'b0, '0};
      key = value[ELEM_W-1:0];
      kept = 0;
      cmd_seen[cmd]++;
      case (cmd)
         CMD_ENQ: begin
            if (shadow_held >= DEPTH) begin
               r.status = ST_FULL;
               full_rejects++;
            end else begin
               shadow_slots[(shadow_head + shadow_held) % DEPTH] = key;
               shadow_held++;
            end
         end
         CMD_DEQ: begin
            if (shadow_held == 0) begin
               r.status = ST_EMPTY;
               empty_dequeues++;
            end else begin
               r.data = DATA_W'(shadow_slots[shadow_head]);
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_held--;
            end
         end
         CMD_FIND: begin
            for (int i = 0; i < shadow_held; i++) begin
               if (shadow_slots[(shadow_head + i) % DEPTH] == key) r.found = 1'b1;
            end
            if (r.found) search_hits++;
         end
         default: begin
            for (int i = 0; i < shadow_held; i++) begin
               e = shadow_slots[(shadow_head + i) % DEPTH];
               if (e != key) begin
                  shadow_slots[(shadow_head + kept) % DEPTH] = e;
                  kept++;
               end
            end
            entries_purged += shadow_held - kept;
            shadow_held = kept;
         end
      endcase
      r.occupancy = OCC_W'(shadow_held);
      return r;
   endfunction

   // Presents one item, waits for its acceptance and records what is due.
   task automatic send_item(input cmd_type cmd, input logic [VAL_W-1:0] value,
                            input bit typed, input queue_reply_type typed_reply);
      int              gap;
      queue_reply_type predicted;
      if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.value <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = apply_queue_command(cmd, value);
      replies_due.push_back(typed ? typed_reply : predicted);
      commands_sent++;
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (replies_due.size() > 0) @(negedge clock);
   endtask

   initial begin : result_taker
      int              gap;
      queue_reply_type want;
      queue_reply_type got;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 29) == 0) take_quiet = !take_quiet;
         gap = take_quiet ? 0 : $urandom_range(0, 19);
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got.status    = status_type'(rsp_chan.status);
         got.data      = rsp_chan.data;
         got.found     = rsp_chan.found;
         got.occupancy = rsp_chan.occupancy;
         results_taken++;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with nothing expected: status %0d data %h",
                        results_taken, got.status, got.data);
         end else begin
            want = replies_due.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.found !== want.found || got.occupancy !== want.occupancy) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result %0d: expected status %0d data %h found %0d occ %0d",
                           results_taken, want.status, want.data, want.found,
                           want.occupancy);
                  $display("result %0d: got      status %0d data %h found %0d occ %0d",
                           results_taken, got.status, got.data, got.found,
                           got.occupancy);
               end
            end
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      cmd_type          cmd;
      logic [VAL_W-1:0] value;
      int               pick;
      bit               filling;

      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd   = CMD_ENQ;
      req_chan.value = '0;
      shadow_head    = 0;
      shadow_held    = 0;
      send_quiet     = 1'b0;
      take_quiet     = 1'b0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;

      // Rows with a reply typed in are checked against that; the others
      // against the shadow queue. Repeated rows step the value by one.
      directed_rows = '{
         '{CMD_DEQ,   32'h0000_0000, 8'd1,  1'b1, '{ST_EMPTY, 32'h0, 1'b0, 5'd0}},
         '{CMD_FIND,  32'h0000_0000, 8'd1,  1'b1, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_PURGE, 32'hFFFF_FFFF, 8'd1,  1'b1, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_ENQ,   32'h0000_0000, 8'd1,  1'b1, '{ST_DONE,  32'h0, 1'b0, 5'd1}},
         '{CMD_ENQ,   32'hFFFF_FFFF, 8'd1,  1'b1, '{ST_DONE,  32'h0, 1'b0, 5'd2}},
         '{CMD_DEQ,   32'h0000_0000, 8'd1,  1'b1, '{ST_DONE,  32'h0, 1'b0, 5'd1}},
         '{CMD_FIND,  32'hFFFF_FFFF, 8'd1,  1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_ENQ,   32'h8000_0000, 8'd15, 1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_ENQ,   32'hDEAD_BEEF, 8'd1,  1'b1, '{ST_FULL,  32'h0, 1'b0, 5'd16}},
         '{CMD_FIND,  32'h1234_5678, 8'd1,  1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_PURGE, 32'h8000_0003, 8'd1,  1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_DEQ,   32'h0000_0000, 8'd1,  1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_ENQ,   32'h8000_0005, 8'd1,  1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}},
         '{CMD_PURGE, 32'h8000_0005, 8'd1,  1'b0, '{ST_DONE,  32'h0, 1'b0, 5'd0}}
      };

      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_item(directed_rows[r].cmd, directed_rows[r].value + VAL_W'(k),
                      directed_rows[r].typed, directed_rows[r].reply);
      end

      hold_until_drained();

      // Alternating stretches that favour filling and draining, so that the
      // queue swings between empty and full and the pointers wrap often.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) hold_until_drained();
         filling = ((n / 40) % 2) == 0;
         pick = $urandom_range(0, 99);
         if (filling)
            cmd = (pick < 65) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                  (pick < 90) ? CMD_FIND : CMD_PURGE;
         else
            cmd = (pick < 20) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                  (pick < 90) ? CMD_FIND : CMD_PURGE;
         value = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom) :
                 key_pool[$urandom_range(0, 7)];
         send_item(cmd, value, 1'b0, '0);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (replies_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d commands, %0d results; enqueue %0d, dequeue %0d",
               commands_sent, results_taken, cmd_seen[CMD_ENQ], cmd_seen[CMD_DEQ]);
      $display("summary: search %0d, purge %0d, %0d rejected when full",
               cmd_seen[CMD_FIND], cmd_seen[CMD_PURGE], full_rejects);
      $display("summary: %0d empty dequeues, %0d search hits, %0d purged, %0d mismatches",
               empty_dequeues, search_hits, entries_purged, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[fifo_queue_with_search_purge.f]
+incdir+rtl
rtl/fqsp_pkg.sv
rtl/fqsp_req_if.sv
rtl/fqsp_rsp_if.sv
rtl/fqsp_store.sv
rtl/fifo_queue_with_search_purge.sv
tb/sv/fifo_queue_with_search_purge_tb.sv
